// ----- sv/erfig_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// erfig_pkg: shared types and constants of the ring face index generator
// Holds the field widths, register indexes, section codes and result type.
// ----------------------------------------------------------------------------
package erfig_pkg;

    // Default sizing of the generator.
    localparam int MAX_RING_DEF   = 256;
    localparam int MAX_LAYERS_DEF = 255;

    // Fixed field widths.
    localparam int VERTEX_W      = 16;
    localparam int RING_FIELD_W  = 9;
    localparam int LAYER_FIELD_W = 8;
    localparam int CFG_DATA_W    = 9;
    localparam int CFG_INDEX_W   = 1;

    // Register values after reset and the smallest usable ring.
    localparam int RING_RESET  = 4;
    localparam int LAYER_RESET = 1;
    localparam int MIN_RING    = 3;

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_RING_POINTS = 1'b0,
        REG_LAYER_COUNT = 1'b1
    } cfg_index_t;

    // Sections of the triangle list.
    typedef enum logic [2:0] {
        PH_BAND   = 3'd0,
        PH_CLOSE  = 3'd1,
        PH_CAPS   = 3'd2,
        PH_ZIG    = 3'd3,
        PH_CENTRE = 3'd4,
        PH_DONE   = 3'd5
    } phase_t;

    // One triangle as it leaves the generator.
    typedef struct packed {
        logic [VERTEX_W-1:0] vertex_a;
        logic [VERTEX_W-1:0] vertex_b;
        logic [VERTEX_W-1:0] vertex_c;
        logic                face_valid;
        logic                last_face;
    } face_t;

endpackage

// ----- sv/erfig_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// erfig_if: channel interfaces of the ring face index generator
// Step request channel, triangle result channel and configuration write port.
// ----------------------------------------------------------------------------
interface erfig_step_if;
    logic valid;
    logic ready;
    logic restart;

    modport source (output valid, output restart, input ready);
    modport sink (input valid, input restart, output ready);
endinterface

interface erfig_face_if;
    import erfig_pkg::*;

    logic                valid;
    logic                ready;
    logic [VERTEX_W-1:0] vertex_a;
    logic [VERTEX_W-1:0] vertex_b;
    logic [VERTEX_W-1:0] vertex_c;
    logic                face_valid;
    logic                last_face;

    modport source (output valid, output vertex_a, output vertex_b, output vertex_c,
                    output face_valid, output last_face, input ready);
    modport sink (input valid, input vertex_a, input vertex_b, input vertex_c,
                  input face_valid, input last_face, output ready);
endinterface

interface erfig_cfg_if;
    import erfig_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ----- sv/erfig_cfg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// erfig_cfg: configuration registers
// Stores the clamped ring size and layer count and the base index of the
// top layer, which is recomputed on every register write.
// ----------------------------------------------------------------------------
module erfig_cfg #(
    parameter int MAX_RING   = erfig_pkg::MAX_RING_DEF,
    parameter int MAX_LAYERS = erfig_pkg::MAX_LAYERS_DEF,
    parameter int RING_W     = $clog2(MAX_RING + 1),
    parameter int LAYER_W    = $clog2(MAX_LAYERS + 1)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    erfig_cfg_if.sink                     cfg,
    output logic [RING_W-1:0]             ring_eff,
    output logic [LAYER_W-1:0]            layer_eff,
    output logic [erfig_pkg::VERTEX_W-1:0] top_base
);
    import erfig_pkg::*;

    localparam int RING_RST  = (MAX_RING < RING_RESET) ? MAX_RING : RING_RESET;
    localparam int LAYER_RST = (MAX_LAYERS < LAYER_RESET) ? MAX_LAYERS : LAYER_RESET;
    localparam int TOP_RST   = RING_RST * LAYER_RST;

    logic [RING_W-1:0]   ring_reg, ring_next;
    logic [LAYER_W-1:0]  layer_reg, layer_next;
    logic [VERTEX_W-1:0] top_reg, top_next;
    logic [RING_W-1:0]   ring_clamped;
    logic [LAYER_W-1:0]  layer_clamped;
    logic [RING_FIELD_W-1:0]  ring_field;
    logic [LAYER_FIELD_W-1:0] layer_field;

    assign cfg.ready   = 1'b1;
    assign ring_field  = cfg.data[RING_FIELD_W-1:0];
    assign layer_field = cfg.data[LAYER_FIELD_W-1:0];

    // Out-of-range values are pulled to the nearest usable one.
    always_comb
    begin
        if (32'(ring_field) < 32'(MIN_RING))
            ring_clamped = RING_W'(MIN_RING);
        else if (32'(ring_field) > 32'(MAX_RING))
            ring_clamped = RING_W'(MAX_RING);
        else
            ring_clamped = RING_W'(ring_field);

        if (layer_field == '0)
            layer_clamped = LAYER_W'(1);
        else if (32'(layer_field) > 32'(MAX_LAYERS))
            layer_clamped = LAYER_W'(MAX_LAYERS);
        else
            layer_clamped = LAYER_W'(layer_field);
    end

    always_comb
    begin
        ring_next  = ring_reg;
        layer_next = layer_reg;
        top_next   = top_reg;
        if (cfg.valid)
        begin
            unique case (cfg_index_t'(cfg.index))
                REG_RING_POINTS:
                begin
                    ring_next = ring_clamped;
                    top_next  = VERTEX_W'(ring_clamped) * VERTEX_W'(layer_reg);
                end
                REG_LAYER_COUNT:
                begin
                    layer_next = layer_clamped;
                    top_next   = VERTEX_W'(ring_reg) * VERTEX_W'(layer_clamped);
                end
                default:
                begin
                    ring_next = ring_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ring_reg  <= RING_W'(RING_RST);
            layer_reg <= LAYER_W'(LAYER_RST);
            top_reg   <= VERTEX_W'(TOP_RST);
        end
        else
        begin
            ring_reg  <= ring_next;
            layer_reg <= layer_next;
            top_reg   <= top_next;
        end
    end

    assign ring_eff  = ring_reg;
    assign layer_eff = layer_reg;
    assign top_base  = top_reg;

endmodule

// ----- sv/erfig_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// erfig_core: triangle sequencer
// Holds the list position and, for each step, forms one triangle and the
// position of the next one.
// ----------------------------------------------------------------------------
module erfig_core #(
    parameter int MAX_RING   = erfig_pkg::MAX_RING_DEF,
    parameter int MAX_LAYERS = erfig_pkg::MAX_LAYERS_DEF,
    parameter int RING_W     = $clog2(MAX_RING + 1),
    parameter int LAYER_W    = $clog2(MAX_LAYERS + 1)
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [RING_W-1:0]              ring_eff,
    input  logic [LAYER_W-1:0]             layer_eff,
    input  logic [erfig_pkg::VERTEX_W-1:0] top_base,
    input  logic                           step_en,
    input  logic                           restart,
    output erfig_pkg::face_t               face
);
    import erfig_pkg::*;

    localparam int IDX_W = $clog2(MAX_RING);

    phase_t              phase_reg, phase_next;
    logic [LAYER_W-1:0]  layer_idx_reg, layer_idx_next;
    logic [IDX_W-1:0]    ring_idx_reg, ring_idx_next;
    logic [VERTEX_W-1:0] layer_base_reg, layer_base_next;
    logic [1:0]          slot_reg, slot_next;
    logic [IDX_W-1:0]    cap_low_reg, cap_low_next;
    logic [IDX_W-1:0]    cap_high_reg, cap_high_next;

    always_comb
    begin
        phase_t              ph;
        logic [LAYER_W-1:0]  li;
        logic [IDX_W-1:0]    ri;
        logic [VERTEX_W-1:0] lb;
        logic [1:0]          fs;
        logic [IDX_W-1:0]    cl;
        logic [IDX_W-1:0]    ch;
        logic [VERTEX_W-1:0] nr16;
        logic [VERTEX_W-1:0] lo;
        logic [VERTEX_W-1:0] hi;
        logic [VERTEX_W-1:0] r16;
        logic [VERTEX_W-1:0] cl16;
        logic [VERTEX_W-1:0] ch16;
        logic [VERTEX_W-1:0] half16;
        phase_t              after_zig;

        ph = phase_reg;
        li = layer_idx_reg;
        ri = ring_idx_reg;
        lb = layer_base_reg;
        fs = slot_reg;
        cl = cap_low_reg;
        ch = cap_high_reg;
        face = '0;
        after_zig = ring_eff[0] ? PH_DONE : PH_CENTRE;

        if (restart)
        begin
            ph = PH_BAND;
            li = '0;
            ri = '0;
            lb = '0;
            fs = '0;
            cl = IDX_W'(1);
            ch = IDX_W'(ring_eff - RING_W'(1));
        end

        // Skip sections whose bounds are already met.
        if (ph == PH_BAND)
        begin
            if (li >= layer_eff)
            begin
                ph = PH_CAPS;
                fs = '0;
            end
            else if (RING_W'(ri) >= ring_eff - RING_W'(1))
            begin
                ph = PH_CLOSE;
                fs = '0;
            end
        end
        if (ph == PH_ZIG && !((IDX_W+1)'(cl) + (IDX_W+1)'(2) < (IDX_W+1)'(ch)))
        begin
            ph = after_zig;
            fs = '0;
        end

        nr16   = VERTEX_W'(ring_eff);
        lo     = lb;
        hi     = lb + nr16;
        r16    = VERTEX_W'(ri);
        cl16   = VERTEX_W'(cl);
        ch16   = VERTEX_W'(ch);
        half16 = VERTEX_W'(ring_eff >> 1);

        face.face_valid = 1'b1;
        unique case (ph)
            PH_BAND:
            begin
                if (fs == 2'd0)
                begin
                    face.vertex_a = lo + r16 + 16'd1;
                    face.vertex_b = lo + r16;
                    face.vertex_c = hi + r16;
                    fs = 2'd1;
                end
                else
                begin
                    face.vertex_a = lo + r16 + 16'd1;
                    face.vertex_b = hi + r16;
                    face.vertex_c = hi + r16 + 16'd1;
                    fs = 2'd0;
                    ri = ri + IDX_W'(1);
                end
            end
            PH_CLOSE:
            begin
                if (fs == 2'd0)
                begin
                    face.vertex_a = lo;
                    face.vertex_b = lo + nr16 - 16'd1;
                    face.vertex_c = hi + nr16 - 16'd1;
                    fs = 2'd1;
                end
                else
                begin
                    face.vertex_a = lo;
                    face.vertex_b = hi + nr16 - 16'd1;
                    face.vertex_c = hi;
                    fs = 2'd0;
                    ri = '0;
                    li = li + LAYER_W'(1);
                    lb = lb + nr16;
                    ph = PH_BAND;
                end
            end
            PH_CAPS:
            begin
                if (fs == 2'd0)
                begin
                    face.vertex_a = '0;
                    face.vertex_b = 16'd1;
                    face.vertex_c = nr16 - 16'd1;
                    fs = 2'd1;
                end
                else
                begin
                    face.vertex_a = top_base + 16'd1;
                    face.vertex_b = top_base;
                    face.vertex_c = top_base + nr16 - 16'd1;
                    fs = 2'd0;
                    cl = IDX_W'(1);
                    ch = IDX_W'(ring_eff - RING_W'(1));
                    ph = PH_ZIG;
                end
            end
            PH_ZIG:
            begin
                case (fs)
                    2'd0:
                    begin
                        face.vertex_a = cl16;
                        face.vertex_b = cl16 + 16'd1;
                        face.vertex_c = ch16;
                    end
                    2'd1:
                    begin
                        face.vertex_a = ch16;
                        face.vertex_b = cl16 + 16'd1;
                        face.vertex_c = ch16 - 16'd1;
                    end
                    2'd2:
                    begin
                        face.vertex_a = top_base + cl16 + 16'd1;
                        face.vertex_b = top_base + cl16;
                        face.vertex_c = top_base + ch16;
                    end
                    default:
                    begin
                        face.vertex_a = top_base + ch16;
                        face.vertex_b = top_base + ch16 - 16'd1;
                        face.vertex_c = top_base + cl16 + 16'd1;
                    end
                endcase
                if (fs == 2'd3)
                begin
                    fs = 2'd0;
                    cl = cl + IDX_W'(1);
                    ch = ch - IDX_W'(1);
                end
                else
                begin
                    fs = fs + 2'd1;
                end
            end
            PH_CENTRE:
            begin
                if (fs == 2'd0)
                begin
                    face.vertex_a = cl16;
                    face.vertex_b = half16;
                    face.vertex_c = ch16;
                    fs = 2'd1;
                end
                else
                begin
                    face.vertex_a = top_base + half16;
                    face.vertex_b = top_base + cl16;
                    face.vertex_c = top_base + ch16;
                    fs = 2'd0;
                    ph = PH_DONE;
                end
            end
            default:
            begin
                // List finished: an empty result with all fields zero.
                face = '0;
            end
        endcase

        if (face.face_valid)
        begin
            if (ph == PH_BAND)
            begin
                if (li >= layer_eff)
                begin
                    ph = PH_CAPS;
                    fs = '0;
                end
                else if (RING_W'(ri) >= ring_eff - RING_W'(1))
                begin
                    ph = PH_CLOSE;
                    fs = '0;
                end
            end
            if (ph == PH_ZIG && !((IDX_W+1)'(cl) + (IDX_W+1)'(2) < (IDX_W+1)'(ch)))
            begin
                ph = after_zig;
                fs = '0;
            end
            face.last_face = (ph == PH_DONE);
        end

        phase_next      = ph;
        layer_idx_next  = li;
        ring_idx_next   = ri;
        layer_base_next = lb;
        slot_next       = fs;
        cap_low_next    = cl;
        cap_high_next   = ch;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_DONE;
            layer_idx_reg  <= '0;
            ring_idx_reg   <= '0;
            layer_base_reg <= '0;
            slot_reg       <= '0;
            cap_low_reg    <= IDX_W'(1);
            cap_high_reg   <= '0;
        end
        else if (step_en)
        begin
            phase_reg      <= phase_next;
            layer_idx_reg  <= layer_idx_next;
            ring_idx_reg   <= ring_idx_next;
            layer_base_reg <= layer_base_next;
            slot_reg       <= slot_next;
            cap_low_reg    <= cap_low_next;
            cap_high_reg   <= cap_high_next;
        end
    end

endmodule

// ----- sv/extruded_ring_face_index_generator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// extruded_ring_face_index_generator: triangle index list of an extruded ring
// Emits the triangles of a closed extruded-ring mesh, one per step request.
// ----------------------------------------------------------------------------
// Usage:
// The configuration port writes ring_points (index 0) and layer_count
// (index 1); it is always ready and should only be written while no step is
// in flight. Each transfer on step_in asks for one triangle: restart set
// begins the list again at its first triangle, restart clear moves on to the
// next one. Every step transfer yields exactly one transfer on face_out,
// carrying three vertex indices, face_valid and last_face. Once the list has
// ended, further steps return face_valid low with all other fields zero.
// A step transfer is first registered in the input stage; the sequencer then
// forms its triangle, which is registered in the output register that drives
// face_out. The block takes one step per cycle while face_out does not
// stall. When face_out stalls, one further step is still taken into the input
// stage; after that step_in.ready follows face_out.ready. After reset the list
// is finished (steps give empty results until a restart), ring_points reads 4
// and layer_count reads 1.
// ----------------------------------------------------------------------------
module extruded_ring_face_index_generator #(
    parameter int MAX_RING   = erfig_pkg::MAX_RING_DEF,
    parameter int MAX_LAYERS = erfig_pkg::MAX_LAYERS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    erfig_cfg_if.sink    cfg,
    erfig_step_if.sink   step_in,
    erfig_face_if.source face_out
);
    import erfig_pkg::*;

    localparam int RING_W  = $clog2(MAX_RING + 1);
    localparam int LAYER_W = $clog2(MAX_LAYERS + 1);

    logic [RING_W-1:0]   ring_eff;
    logic [LAYER_W-1:0]  layer_eff;
    logic [VERTEX_W-1:0] top_base;

    // Input stage holding one accepted step.
    logic  in_valid_reg, in_valid_next;
    logic  in_restart_reg, in_restart_next;

    // Output register holding one finished triangle.
    logic  out_valid_reg, out_valid_next;
    face_t face_reg, face_next;

    face_t face_comb;
    logic  advance;
    logic  step_en;

    erfig_cfg #(
        .MAX_RING   (MAX_RING),
        .MAX_LAYERS (MAX_LAYERS),
        .RING_W     (RING_W),
        .LAYER_W    (LAYER_W)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .ring_eff  (ring_eff),
        .layer_eff (layer_eff),
        .top_base  (top_base)
    );

    erfig_core #(
        .MAX_RING   (MAX_RING),
        .MAX_LAYERS (MAX_LAYERS),
        .RING_W     (RING_W),
        .LAYER_W    (LAYER_W)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .ring_eff  (ring_eff),
        .layer_eff (layer_eff),
        .top_base  (top_base),
        .step_en   (step_en),
        .restart   (in_restart_reg),
        .face      (face_comb)
    );

    // The pipeline moves whenever the output register is empty or being read.
    assign advance       = !out_valid_reg || face_out.ready;
    assign step_en       = in_valid_reg && advance;
    assign step_in.ready = !in_valid_reg || advance;

    always_comb
    begin
        in_valid_next   = in_valid_reg;
        in_restart_next = in_restart_reg;
        out_valid_next  = out_valid_reg;
        face_next       = face_reg;

        if (step_in.ready)
        begin
            in_valid_next   = step_in.valid;
            in_restart_next = step_in.restart;
        end
        if (advance)
        begin
            out_valid_next = in_valid_reg;
            if (in_valid_reg)
                face_next = face_comb;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        in_restart_reg <= in_restart_next;
        face_reg       <= face_next;
    end

    assign face_out.valid      = out_valid_reg;
    assign face_out.vertex_a   = face_reg.vertex_a;
    assign face_out.vertex_b   = face_reg.vertex_b;
    assign face_out.vertex_c   = face_reg.vertex_c;
    assign face_out.face_valid = face_reg.face_valid;
    assign face_out.last_face  = face_reg.last_face;

endmodule
